/* design/contact_process_lattice_update_core_macros.svh */
// ----------------------------------------------------------------------------
// contact process lattice update: assertion macros
// shared concurrent assertion forms, clocked on clk, quiet while arst_n is low
// ----------------------------------------------------------------------------
`ifndef CONTACT_PROCESS_LATTICE_UPDATE_CORE_MACROS_SVH
`define CONTACT_PROCESS_LATTICE_UPDATE_CORE_MACROS_SVH

// same-cycle implication
`define CPLU_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("%m: same-cycle check failed");

// next-cycle implication
`define CPLU_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("%m: next-cycle check failed");

`endif

/* design/cplu_pkg.sv */
// ----------------------------------------------------------------------------
// cplu_pkg
// lattice geometry, memory layout, payload types and helpers for the
// contact process lattice update block
// ----------------------------------------------------------------------------
`default_nettype none

package cplu_pkg;

	// lattice side, a power of two from 4 to 1024
	localparam int GRID_SIDE = 1024;
	localparam int GRID_W    = $clog2(GRID_SIDE);
	localparam int CENTER    = GRID_SIDE / 2;

	// field widths fixed by the interface
	localparam int COORD_W = 10;
	localparam int DRAW_W  = 16;
	localparam int THR_W   = 16;
	localparam int COUNT_W = 21;
	localparam int SUM_W   = 38;
	localparam int DSQ_W   = 2 * GRID_W + 1;

	// occupancy bits packed into memory words
	localparam int CELLS     = GRID_SIDE * GRID_SIDE;
	localparam int IDX_W     = 2 * GRID_W;
	localparam int WORD_BITS = 64;
	localparam int BIT_W     = $clog2(WORD_BITS);
	localparam int WORDS     = (CELLS + WORD_BITS - 1) / WORD_BITS;
	localparam int ADDR_W    = (WORDS > 1) ? $clog2(WORDS) : 1;
	localparam int PIDX_W    = IDX_W + BIT_W;
	localparam int EXT_W     = (GRID_W > COORD_W) ? GRID_W : COORD_W;

	localparam int CENTER_IDX  = CENTER * GRID_SIDE + CENTER;
	localparam int CENTER_WORD = CENTER_IDX / WORD_BITS;
	localparam int CENTER_BIT  = CENTER_IDX % WORD_BITS;

	// configuration register map
	localparam int CFG_IDX_W = 4;
	localparam logic [CFG_IDX_W-1:0] REG_DEATH = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_BIRTH = CFG_IDX_W'(1);
	localparam logic [THR_W-1:0] DEATH_RESET = THR_W'(9994);
	localparam logic [THR_W-1:0] BIRTH_RESET = THR_W'(16384);

	typedef enum logic [1:0] {
		DIR_LEFT  = 2'd0,
		DIR_RIGHT = 2'd1,
		DIR_UP    = 2'd2,
		DIR_DOWN  = 2'd3
	} dir_t;

	typedef struct packed {
		logic [COORD_W-1:0] site_x;
		logic [COORD_W-1:0] site_y;
		logic [1:0]         direction;
		logic [DRAW_W-1:0]  random_draw;
	} cmd_t;

	typedef struct packed {
		logic               site_occupied;
		logic               site_changed;
		logic [COUNT_W-1:0] occupied_count;
		logic [SUM_W-1:0]   distance_sum;
	} rsp_t;

	// one memory port request
	typedef struct packed {
		logic                 rd_en;
		logic                 wr_en;
		logic [ADDR_W-1:0]    addr;
		logic [WORD_BITS-1:0] wdata;
	} mem_port_t;

	// coordinate reduced onto the lattice (power-of-two side: a mask)
	function automatic logic [GRID_W-1:0] reduce_coord(input logic [COORD_W-1:0] v);
		logic [EXT_W-1:0] ext;
		ext = EXT_W'(v);
		return ext[GRID_W-1:0];
	endfunction

	function automatic logic [IDX_W-1:0] cell_index(input logic [GRID_W-1:0] x,
		input logic [GRID_W-1:0] y);
		return IDX_W'(y) * IDX_W'(GRID_SIDE) + IDX_W'(x);
	endfunction

	function automatic logic [ADDR_W-1:0] word_of(input logic [IDX_W-1:0] idx);
		return ADDR_W'(PIDX_W'(idx) >> BIT_W);
	endfunction

	function automatic logic [BIT_W-1:0] bit_of(input logic [IDX_W-1:0] idx);
		return BIT_W'(idx);
	endfunction

	// squared distance from the lattice centre
	function automatic logic [DSQ_W-1:0] dist_sq(input logic [GRID_W-1:0] x,
		input logic [GRID_W-1:0] y);
		logic [GRID_W-1:0] dx;
		logic [GRID_W-1:0] dy;
		dx = (x >= GRID_W'(CENTER)) ? x - GRID_W'(CENTER) : GRID_W'(CENTER) - x;
		dy = (y >= GRID_W'(CENTER)) ? y - GRID_W'(CENTER) : GRID_W'(CENTER) - y;
		return DSQ_W'(dx) * DSQ_W'(dx) + DSQ_W'(dy) * DSQ_W'(dy);
	endfunction

endpackage

`default_nettype wire

/* design/cplu_grid_mem.sv */
// ----------------------------------------------------------------------------
// cplu_grid_mem
// occupancy memory, one read/write port and one read port, registered reads
// ----------------------------------------------------------------------------
`default_nettype none

module cplu_grid_mem import cplu_pkg::*; (
	input  logic                 clk,
	input  mem_port_t            port_a,
	input  mem_port_t            port_b,
	output logic [WORD_BITS-1:0] rdata_a,
	output logic [WORD_BITS-1:0] rdata_b
);

	logic [WORD_BITS-1:0] mem_q [WORDS];
	logic [WORD_BITS-1:0] rdata_a_q;
	logic [WORD_BITS-1:0] rdata_b_q;

	always_ff @(posedge clk) begin
		if (port_a.wr_en) begin
			mem_q[port_a.addr] <= port_a.wdata;
		end
		if (port_a.rd_en) begin
			rdata_a_q <= mem_q[port_a.addr];
		end
	end

	// port b only reads
	always_ff @(posedge clk) begin
		if (port_b.rd_en) begin
			rdata_b_q <= mem_q[port_b.addr];
		end
	end

	assign rdata_a = rdata_a_q;
	assign rdata_b = rdata_b_q;

endmodule

`default_nettype wire

/* design/cplu_clear.sv */
// ----------------------------------------------------------------------------
// cplu_clear
// post-reset sweep that empties the lattice and seeds the centre site
// ----------------------------------------------------------------------------
`default_nettype none

module cplu_clear import cplu_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	output logic      active,
	output mem_port_t port
);

	logic              active_q;
	logic [ADDR_W-1:0] cnt_q;
	logic              last;

	assign last = (cnt_q == ADDR_W'(WORDS - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b1;
			cnt_q    <= '0;
		end else if (active_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (last) begin
				active_q <= 1'b0;
			end
		end
	end

	always_comb begin
		port       = '0;
		port.wr_en = active_q;
		port.addr  = cnt_q;
		if (cnt_q == ADDR_W'(CENTER_WORD)) begin
			port.wdata[CENTER_BIT] = 1'b1;
		end
	end

	assign active = active_q;

endmodule

`default_nettype wire

/* design/cplu_update.sv */
// ----------------------------------------------------------------------------
// cplu_update
// address generation, occupancy decision, word write-back and running totals
// ----------------------------------------------------------------------------
`default_nettype none

module cplu_update import cplu_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 accept,
	input  cmd_t                 cmd,
	input  logic [THR_W-1:0]     death_thr,
	input  logic [THR_W-1:0]     birth_thr,
	input  logic [WORD_BITS-1:0] rdata_a,
	input  logic [WORD_BITS-1:0] rdata_b,
	output mem_port_t            port_a,
	output mem_port_t            port_b,
	output logic                 pending,
	output logic                 done,
	output rsp_t                 rsp
);

	logic [GRID_W-1:0] x;
	logic [GRID_W-1:0] y;
	logic [GRID_W-1:0] nx;
	logic [GRID_W-1:0] ny;
	logic [IDX_W-1:0]  site_idx;
	logic [IDX_W-1:0]  nbr_idx;

	logic              valid_s1;
	logic [ADDR_W-1:0] addr_s1;
	logic [BIT_W-1:0]  site_bit_s1;
	logic [BIT_W-1:0]  nbr_bit_s1;
	logic [DRAW_W-1:0] draw_s1;
	logic [DSQ_W-1:0]  dsq_s1;

	logic                 occ_old;
	logic                 nbr_occ;
	logic                 change;
	logic                 occ_new;
	logic [WORD_BITS-1:0] wword;
	logic [COUNT_W-1:0]   live_next;
	logic [SUM_W-1:0]     sum_next;

	logic [COUNT_W-1:0] live_q;
	logic [SUM_W-1:0]   sum_q;
	logic               done_q;
	rsp_t               rsp_q;

	// wrapped neighbour
	always_comb begin
		x  = reduce_coord(cmd.site_x);
		y  = reduce_coord(cmd.site_y);
		nx = x;
		ny = y;
		unique case (dir_t'(cmd.direction))
			DIR_LEFT:  nx = (x == '0) ? GRID_W'(GRID_SIDE - 1) : x - 1'b1;
			DIR_RIGHT: nx = (x == GRID_W'(GRID_SIDE - 1)) ? '0 : x + 1'b1;
			DIR_UP:    ny = (y == '0) ? GRID_W'(GRID_SIDE - 1) : y - 1'b1;
			DIR_DOWN:  ny = (y == GRID_W'(GRID_SIDE - 1)) ? '0 : y + 1'b1;
		endcase
		site_idx = cell_index(x, y);
		nbr_idx  = cell_index(nx, ny);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			addr_s1     <= word_of(site_idx);
			site_bit_s1 <= bit_of(site_idx);
			nbr_bit_s1  <= bit_of(nbr_idx);
			draw_s1     <= cmd.random_draw;
			dsq_s1      <= dist_sq(x, y);
		end
	end

	// decision on the words read back
	always_comb begin
		occ_old = rdata_a[site_bit_s1];
		nbr_occ = rdata_b[nbr_bit_s1];
		if (occ_old) begin
			change = (draw_s1 < death_thr);
		end else begin
			change = nbr_occ && (draw_s1 < birth_thr);
		end
		occ_new = occ_old ^ change;
		wword = rdata_a;
		wword[site_bit_s1] = occ_new;
		live_next = live_q;
		sum_next  = sum_q;
		if (change && occ_old) begin
			live_next = live_q - 1'b1;
			sum_next  = sum_q - SUM_W'(dsq_s1);
		end else if (change) begin
			live_next = live_q + 1'b1;
			sum_next  = sum_q + SUM_W'(dsq_s1);
		end
	end

	// read at transfer, write back in the following cycle: never in the same cycle
	always_comb begin
		port_a       = '0;
		port_a.rd_en = accept;
		port_a.wr_en = valid_s1 && change;
		port_a.addr  = valid_s1 ? addr_s1 : word_of(site_idx);
		port_a.wdata = wword;
		port_b       = '0;
		port_b.rd_en = accept;
		port_b.addr  = word_of(nbr_idx);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			live_q <= COUNT_W'(1);
			sum_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= valid_s1;
			if (valid_s1) begin
				live_q <= live_next;
				sum_q  <= sum_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			rsp_q.site_occupied  <= occ_new;
			rsp_q.site_changed   <= change;
			rsp_q.occupied_count <= live_next;
			rsp_q.distance_sum   <= sum_next;
		end
	end

	assign pending = valid_s1;
	assign done    = done_q;
	assign rsp     = rsp_q;

endmodule

`default_nettype wire

/* design/contact_process_lattice_update_core.sv */
// ----------------------------------------------------------------------------
// contact_process_lattice_update_core
// one random-sequential contact process update per command on a toroidal
// occupancy lattice, with running occupied count and squared-distance sum
// ----------------------------------------------------------------------------
// result: done follows the transfer through the valid_s1 and done_q registers
// a new command waits out the write-back, set by the read-modify-write of the
//   occupancy memory (read at transfer, write back in the next cycle)
// reset: a clearing pass over all WORDS words (16384 at a 1024 side) sweeps the
//   memory with busy high; config writes are taken throughout
// results are shown for one cycle and are never stalled by the receiver
`default_nettype none

module contact_process_lattice_update_core import cplu_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	// command channel
	input  logic                 start,
	output logic                 busy,
	input  cmd_t                 cmd,
	// result channel
	output logic                 done,
	output rsp_t                 rsp,
	// configuration channel
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [THR_W-1:0]     cfg_data
);

	logic                 accept;
	logic                 clear_active;
	logic                 pending;
	mem_port_t            clear_port;
	mem_port_t            upd_port_a;
	mem_port_t            upd_port_b;
	mem_port_t            mem_port_a;
	logic [WORD_BITS-1:0] rdata_a;
	logic [WORD_BITS-1:0] rdata_b;
	logic [THR_W-1:0]     death_q;
	logic [THR_W-1:0]     birth_q;

	// busy while the lattice is cleared or a command sits in its write-back cycle
	assign busy   = clear_active || pending;
	assign accept = start && !busy;

	// config is always ready; unknown indexes are dropped
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			death_q <= DEATH_RESET;
			birth_q <= BIRTH_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_DEATH: begin
					death_q <= cfg_data;
				end
				REG_BIRTH: begin
					birth_q <= cfg_data;
				end
				default: begin
				end
			endcase
		end
	end

	cplu_clear u_clear (
		.clk    (clk),
		.arst_n (arst_n),
		.active (clear_active),
		.port   (clear_port)
	);

	cplu_update u_update (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.cmd       (cmd),
		.death_thr (death_q),
		.birth_thr (birth_q),
		.rdata_a   (rdata_a),
		.rdata_b   (rdata_b),
		.port_a    (upd_port_a),
		.port_b    (upd_port_b),
		.pending   (pending),
		.done      (done),
		.rsp       (rsp)
	);

	// clearing sweep owns port a until it ends; no command runs meanwhile
	assign mem_port_a = clear_active ? clear_port : upd_port_a;

	cplu_grid_mem u_grid_mem (
		.clk     (clk),
		.port_a  (mem_port_a),
		.port_b  (upd_port_b),
		.rdata_a (rdata_a),
		.rdata_b (rdata_b)
	);

endmodule

`default_nettype wire

/* design/cplu_checker.sv */
// ----------------------------------------------------------------------------
// cplu_checker
// port-level timing checks of command transfer against result strobes
// ----------------------------------------------------------------------------
`default_nettype none

`include "contact_process_lattice_update_core_macros.svh"

module cplu_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire logic busy,
	input wire logic done
);

	logic cmd_xfer;
	assign cmd_xfer = start && !busy;

	// a transfer holds off the next command and has no result yet
	`CPLU_ASSERT_NEXT(a_xfer_then_busy, cmd_xfer, busy && !done)

	// a result frees the block for the next command
	`CPLU_ASSERT_NOW(a_done_not_busy, done, !busy)

	// every result traces back to a transfer, through the valid_s1 and done_q registers
	`CPLU_ASSERT_NOW(a_done_has_cmd, done, $past(cmd_xfer, 2))

	// results never fall on back-to-back cycles
	`CPLU_ASSERT_NEXT(a_done_spaced, done, !done)

endmodule

bind contact_process_lattice_update_core cplu_checker u_cplu_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done)
);

`default_nettype wire
